>>> hdl/gsp_pkg.sv
// ----------------------------------------------------------------------------
// gsp_pkg: shared constants and types for the gas sensor ppm converter
// Fixed-point constants for the power law and the log unit control struct.
// ----------------------------------------------------------------------------
package gsp_pkg;

    localparam int unsigned LOG_FRAC = 24;
    localparam logic [31:0] POWER_Q24 = 32'd40383365;
    localparam logic [31:0] LOG2_SCALE_Q24 = 32'd155388223;
    localparam logic [31:0] CAL_FACTOR_Q32 = 32'd1035500461;
    localparam logic [23:0] PPM_MAX = 24'hFFFFFF;
    localparam logic [15:0] WARMUP_RESET = 16'd3000;

    // log2 in Q5.24 (29 bits)
    typedef logic [28:0] lg_t;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } lg_ctrl_t;

endpackage

>>> hdl/gas_sensor_ppm_converter.sv
// ----------------------------------------------------------------------------
// gas_sensor_ppm_converter: adc code to gas ppm by a power law
// Serial divider, iterative log2 and bisection search for the output.
// ----------------------------------------------------------------------------
// Usage: the input channel (sample, uptime_ms, in_valid/in_ready) takes one
// adc beat; the output channel (ppm and flags, out_valid/out_ready) returns
// one beat per input. warmup_ms is written through cfg_we/cfg_data while idle.
// One item at a time: a bit-serial restoring divider forms RS, then the
// shared log2 unit runs for R0, RS, the saturation bound and each of 24
// bisection probes. A zero code skips the divider and the log unit and
// finishes with invalid_sample set.
// The result waits in the output register while out_ready is low; a new
// beat is accepted only once it has been taken.
// Reset sets warmup_ms to 3000 and the clean-air resistance to 14 kohm.
// ----------------------------------------------------------------------------
module gas_sensor_ppm_converter
#(
    parameter int SAMPLE_BITS = 12,
    parameter int FRAC_BITS   = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [11:0]            sample,
    input  logic [31:0]            uptime_ms,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [23:0]            ppm,
    output logic                   calibrated,
    output logic                   saturated,
    output logic                   invalid_sample,
    input  logic                   cfg_we,
    input  logic [15:0]            cfg_data
);

    localparam int NUM_W = SAMPLE_BITS + 3 + FRAC_BITS;
    localparam logic [SAMPLE_BITS-1:0] FULL = '1;

    typedef enum logic [10:0]
    {
        S_IDLE = 11'b00000000001,
        S_DIV  = 11'b00000000010,
        S_CAL  = 11'b00000000100,
        S_LR0  = 11'b00000001000,
        S_LRS  = 11'b00000010000,
        S_MUL  = 11'b00000100000,
        S_LSAT = 11'b00001000000,
        S_BIS  = 11'b00010000000,
        S_LBIS = 11'b00100000000,
        S_OUT  = 11'b01000000000,
        S_DONE = 11'b10000000000
    } state_t;

    state_t                 state_reg, state_next;
    logic [15:0]            warmup_reg;
    logic [31:0]            r0_reg, r0_next;
    logic [SAMPLE_BITS-1:0] code_reg, code_next;
    logic                   warm_reg, warm_next;
    logic [NUM_W-1:0]       num_reg, num_next;
    logic [NUM_W:0]         rem_reg, rem_next;
    logic [NUM_W-1:0]       quo_reg, quo_next;
    logic [5:0]             cnt_reg, cnt_next;
    logic [31:0]            rs_reg, rs_next;
    gsp_pkg::lg_t           lr0_reg, lr0_next;
    logic signed [31:0]     t_reg, t_next;
    logic [23:0]            lo_reg, lo_next, hi_reg, hi_next;
    logic [23:0]            mid_reg, mid_next;
    logic                   cal_reg, cal_next;
    logic                   sat_reg, sat_next;
    logic                   inv_reg, inv_next;
    logic                   ov_reg, ov_next;
    logic                   lg_start;
    logic [31:0]            lg_x;
    gsp_pkg::lg_ctrl_t      lg_ctrl;
    gsp_pkg::lg_t           lg_res;

    logic [SAMPLE_BITS-1:0] code_in;
    logic [NUM_W:0]         rem_sh;
    logic [63:0]            cal_prod;
    logic signed [30:0]     l_diff;
    logic [29:0]            l_mag;
    logic [61:0]            e_prod;
    logic [37:0]            e_q;
    logic [24:0]            mid_w;

    gsp_log2 u_log2
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (lg_start),
        .x      (lg_x),
        .ctrl   (lg_ctrl),
        .result (lg_res)
    );

    assign code_in  = SAMPLE_BITS'(sample);
    assign rem_sh   = {rem_reg[NUM_W-1:0], num_reg[NUM_W-1]};
    assign cal_prod = rs_reg * gsp_pkg::CAL_FACTOR_Q32;
    assign l_diff   = $signed({2'b00, lr0_reg}) - $signed({2'b00, lg_res});
    assign l_mag    = l_diff[30] ? 30'(-l_diff) : 30'(l_diff);
    assign e_prod   = l_mag * gsp_pkg::POWER_Q24;
    assign e_q      = 38'((e_prod + 62'(1 << (gsp_pkg::LOG_FRAC - 1))) >> gsp_pkg::LOG_FRAC);
    assign mid_w    = {1'b0, lo_reg} + ((25'({1'b0, hi_reg}) - 25'({1'b0, lo_reg}) + 25'd1) >> 1);

    always_comb
    begin
        state_next = state_reg;
        r0_next    = r0_reg;
        code_next  = code_reg;
        warm_next  = warm_reg;
        num_next   = num_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        rs_next    = rs_reg;
        lr0_next   = lr0_reg;
        t_next     = t_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        cal_next   = cal_reg;
        sat_next   = sat_reg;
        inv_next   = inv_reg;
        ov_next    = ov_reg;
        lg_start   = 1'b0;
        lg_x       = r0_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    code_next = code_in;
                    warm_next = (uptime_ms < {16'd0, warmup_reg});
                    cal_next  = 1'b0;
                    sat_next  = 1'b0;
                    inv_next  = 1'b0;
                    num_next  = NUM_W'(NUM_W'(FULL - code_in) * NUM_W'(5)) << FRAC_BITS;
                    rem_next  = '0;
                    quo_next  = '0;
                    cnt_next  = '0;
                    if (code_in == '0)
                    begin
                        inv_next   = 1'b1;
                        lo_next    = '0;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                // restoring division, one quotient bit per cycle
                num_next = {num_reg[NUM_W-2:0], 1'b0};
                if (rem_sh >= (NUM_W+1)'(code_reg))
                begin
                    rem_next = rem_sh - (NUM_W+1)'(code_reg);
                    quo_next = {quo_reg[NUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh;
                    quo_next = {quo_reg[NUM_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(NUM_W - 1))
                begin
                    state_next = S_CAL;
                end
            end
            S_CAL:
            begin
                if (NUM_W > 32 && quo_reg > NUM_W'(33'hFFFFFFFF))
                begin
                    rs_next = '1;
                end
                else
                begin
                    rs_next = 32'(quo_reg);
                end
                state_next = S_LR0;
                if (quo_reg == '0)
                begin
                    sat_next   = 1'b1;
                    lo_next    = gsp_pkg::PPM_MAX;
                    state_next = S_OUT;
                end
            end
            S_LR0:
            begin
                if (warm_reg && !cal_reg)
                begin
                    r0_next  = (cal_prod[63:32] == '0) ? 32'd1 : cal_prod[63:32];
                    cal_next = 1'b1;
                end
                else if (r0_reg == '0)
                begin
                    lo_next    = '0;
                    state_next = S_OUT;
                end
                else if (!lg_ctrl.busy && !lg_ctrl.done)
                begin
                    lg_x       = r0_reg;
                    lg_start   = 1'b1;
                    state_next = S_LRS;
                end
            end
            S_LRS:
            begin
                if (lg_ctrl.done)
                begin
                    lr0_next   = lg_res;
                    lg_x       = rs_reg;
                    lg_start   = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                if (lg_ctrl.done)
                begin
                    t_next = (l_diff[30] ? -$signed(32'(e_q)) : $signed(32'(e_q)))
                             + $signed(gsp_pkg::LOG2_SCALE_Q24) + $signed(32'd16777216);
                    lg_x       = 32'h01FFFFFF;
                    lg_start   = 1'b1;
                    state_next = S_LSAT;
                end
            end
            S_LSAT:
            begin
                if (lg_ctrl.done)
                begin
                    if ($signed({3'b000, lg_res}) <= t_reg)
                    begin
                        sat_next   = 1'b1;
                        lo_next    = gsp_pkg::PPM_MAX;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        lo_next    = '0;
                        hi_next    = gsp_pkg::PPM_MAX;
                        state_next = S_BIS;
                    end
                end
            end
            S_BIS:
            begin
                if (lo_reg == hi_reg)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    mid_next   = mid_w[23:0];
                    lg_x       = {7'd0, mid_w[23:0], 1'b0} - 32'd1;
                    lg_start   = 1'b1;
                    state_next = S_LBIS;
                end
            end
            S_LBIS:
            begin
                if (lg_ctrl.done)
                begin
                    if ($signed({3'b000, lg_res}) <= t_reg)
                    begin
                        lo_next = mid_reg;
                    end
                    else
                    begin
                        hi_next = mid_reg - 24'd1;
                    end
                    state_next = S_BIS;
                end
            end
            S_OUT:
            begin
                ov_next    = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_ready)
                begin
                    ov_next    = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            warmup_reg <= gsp_pkg::WARMUP_RESET;
            r0_reg     <= 32'(14) << FRAC_BITS;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            r0_reg    <= r0_next;
            ov_reg    <= ov_next;
            if (cfg_we)
            begin
                warmup_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg <= code_next;
        warm_reg <= warm_next;
        num_reg  <= num_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        cnt_reg  <= cnt_next;
        rs_reg   <= rs_next;
        lr0_reg  <= lr0_next;
        t_reg    <= t_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        mid_reg  <= mid_next;
        cal_reg  <= cal_next;
        sat_reg  <= sat_next;
        inv_reg  <= inv_next;
    end

    assign in_ready       = (state_reg == S_IDLE);
    assign out_valid      = ov_reg;
    assign ppm            = lo_reg;
    assign calibrated     = cal_reg;
    assign saturated      = sat_reg;
    assign invalid_sample = inv_reg;

endmodule

>>> hdl/gsp_log2.sv
// ----------------------------------------------------------------------------
// gsp_log2: iterative log2 in Q5.24
// Finds the top set bit one bit per cycle, then one fraction bit per cycle by
// squaring the Q1.31 mantissa.
// ----------------------------------------------------------------------------
module gsp_log2
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [31:0]       x,
    output gsp_pkg::lg_ctrl_t ctrl,
    output gsp_pkg::lg_t      result
);

    typedef enum logic [2:0]
    {
        S_IDLE = 3'b001,
        S_NORM = 3'b010,
        S_FRAC = 3'b100
    } state_t;

    state_t      state_reg, state_next;
    logic [4:0]  n_reg, n_next;
    logic [32:0] m_reg, m_next;
    logic [23:0] f_reg, f_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        done_reg, done_next;
    logic [65:0] sq;
    logic [34:0] sq_sh;

    assign sq    = m_reg * m_reg;
    assign sq_sh = sq[65:31];

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        m_next     = m_reg;
        f_next     = f_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    n_next   = 5'd31;
                    m_next   = {1'b0, x};
                    f_next   = '0;
                    cnt_next = '0;
                    if (x == 32'd0)
                    begin
                        n_next    = '0;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        state_next = S_NORM;
                    end
                end
            end
            S_NORM:
            begin
                // shift left until bit 31 is set
                if (m_reg[31] || n_reg == 5'd0)
                begin
                    state_next = S_FRAC;
                end
                else
                begin
                    m_next = {m_reg[31:0], 1'b0};
                    n_next = n_reg - 5'd1;
                end
            end
            S_FRAC:
            begin
                f_next = {f_reg[22:0], sq_sh[32]};
                m_next = sq_sh[32] ? sq_sh[33:1] : sq_sh[32:0];
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(gsp_pkg::LOG_FRAC - 1))
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        m_reg   <= m_next;
        f_reg   <= f_next;
        cnt_reg <= cnt_next;
    end

    assign ctrl.start = start;
    assign ctrl.busy  = (state_reg != S_IDLE);
    assign ctrl.done  = done_reg;
    assign result     = {n_reg, f_reg};

endmodule

>>> tb/tb_gas_sensor_ppm_converter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gas_sensor_ppm_converter: self-checking bench for the ppm converter
// Drives adc beats with random gaps, predicts ppm and flags with a bit-exact
// fixed-point power-law model, and checks every output beat in order.
// ----------------------------------------------------------------------------
module tb_gas_sensor_ppm_converter;

    localparam int WATCHDOG_LIMIT = 200000;
    localparam logic [11:0] FULL_CODE = 12'hFFF;

    typedef struct packed {
        logic [23:0] ppm;
        logic        calibrated;
        logic        saturated;
        logic        invalid_sample;
    } ppm_beat_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [11:0] sample;
    logic [31:0] uptime_ms;
    logic        out_valid;
    logic        out_ready;
    logic [23:0] ppm;
    logic        calibrated;
    logic        saturated;
    logic        invalid_sample;
    logic        cfg_we;
    logic [15:0] cfg_data;

    // predictor state
    logic [15:0] warmup_limit;
    logic [31:0] r0_kohm;

    ppm_beat_t   expected_beats[$];
    int          error_count;
    int          idle_cycles;
    bit          stall_enable;

    gas_sensor_ppm_converter dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .sample         (sample),
        .uptime_ms      (uptime_ms),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .ppm            (ppm),
        .calibrated     (calibrated),
        .saturated      (saturated),
        .invalid_sample (invalid_sample),
        .cfg_we         (cfg_we),
        .cfg_data       (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // log2 in Q.24 by repeated squaring of the mantissa
    function automatic longint log2_fixed(input logic [31:0] x);
        int          n;
        logic [63:0] m;
        logic [63:0] f;
        n = 31;
        f = '0;
        if (x == 0)
            return 0;
        while (n > 0 && x[n] == 1'b0)
            n--;
        m = 64'(x) << (31 - n);
        for (int i = 0; i < gsp_pkg::LOG_FRAC; i++)
        begin
            m = (m * m) >> 31;
            f = f << 1;
            if (m >= 64'h1_0000_0000)
            begin
                f[0] = 1'b1;
                m = m >> 1;
            end
        end
        return longint'((64'(n) << gsp_pkg::LOG_FRAC) | f);
    endfunction

    function automatic logic [23:0] power_law_ppm(input logic [31:0] rs,
                                                  input logic [31:0] r0,
                                                  output logic sat);
        longint      l;
        longint      e;
        longint      t;
        logic [63:0] mag;
        logic [63:0] q;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] mid;
        sat = 1'b0;
        lo = 0;
        hi = 32'(gsp_pkg::PPM_MAX);
        if (rs == 0)
        begin
            sat = 1'b1;
            return gsp_pkg::PPM_MAX;
        end
        if (r0 == 0)
            return '0;
        l = log2_fixed(r0) - log2_fixed(rs);
        mag = (l < 0) ? 64'(-l) : 64'(l);
        q = (mag * 64'(gsp_pkg::POWER_Q24) + (64'd1 << (gsp_pkg::LOG_FRAC - 1)))
            >> gsp_pkg::LOG_FRAC;
        e = (l < 0) ? -longint'(q) : longint'(q);
        t = e + longint'(gsp_pkg::LOG2_SCALE_Q24) + (longint'(1) << gsp_pkg::LOG_FRAC);
        if (log2_fixed(32'h01FF_FFFF) <= t)
        begin
            sat = 1'b1;
            return gsp_pkg::PPM_MAX;
        end
        while (lo < hi)
        begin
            mid = lo + (hi - lo + 1) / 2;
            if (log2_fixed(2 * mid - 1) <= t)
                lo = mid;
            else
                hi = mid - 1;
        end
        return lo[23:0];
    endfunction

    function automatic ppm_beat_t predict_ppm(input logic [11:0] code,
                                              input logic [31:0] up);
        ppm_beat_t   r;
        logic [63:0] num;
        logic [31:0] rs;
        logic        sat;
        r = '0;
        if (code == 0)
        begin
            r.invalid_sample = 1'b1;
            return r;
        end
        num = (64'd5 * 64'(FULL_CODE - code)) << 16;
        rs = ((num / code) > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(num / code);
        if (up < 32'(warmup_limit) && rs != 0)
        begin
            r0_kohm = 32'((64'(rs) * 64'(gsp_pkg::CAL_FACTOR_Q32)) >> 32);
            if (r0_kohm == 0)
                r0_kohm = 1;
            r.calibrated = 1'b1;
        end
        r.ppm = power_law_ppm(rs, r0_kohm, sat);
        r.saturated = sat;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got,
                                   input longint want);
        $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
        error_count++;
    endtask

    task automatic send_sample(input logic [11:0] code, input logic [31:0] up);
        int gap;
        gap = stall_enable ? $urandom_range(0, 15) : 0;
        repeat (gap) @(negedge clk);
        sample = code;
        uptime_ms = up;
        in_valid = 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_beats.push_back(predict_ppm(code, up));
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic drain_results();
        while (expected_beats.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_warmup(input logic [15:0] value);
        drain_results();
        cfg_data = value;
        cfg_we = 1'b1;
        @(negedge clk);
        cfg_we = 1'b0;
        warmup_limit = value;
    endtask

    // output side: random stall per beat, then compare with the oldest prediction
    initial
    begin
        int stall;
        ppm_beat_t want;
        out_ready = 1'b0;
        forever
        begin
            stall = stall_enable ? $urandom_range(0, 15) : 0;
            repeat (stall) @(negedge clk);
            out_ready = 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            if (expected_beats.size() == 0)
            begin
                report_mismatch("unexpected beat ppm", ppm, 0);
            end
            else
            begin
                want = expected_beats.pop_front();
                if (ppm !== want.ppm)
                    report_mismatch("ppm", ppm, want.ppm);
                if (calibrated !== want.calibrated)
                    report_mismatch("calibrated", calibrated, want.calibrated);
                if (saturated !== want.saturated)
                    report_mismatch("saturated", saturated, want.saturated);
                if (invalid_sample !== want.invalid_sample)
                    report_mismatch("invalid_sample", invalid_sample, want.invalid_sample);
            end
            @(negedge clk);
            out_ready = 1'b0;
        end
    end

    // watchdog on cycles with no beat in either direction
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_gas_sensor_ppm_converter: errors");
            $finish;
        end
    end

    task automatic test_directed_codes();
        logic [11:0] codes[] = '{12'd0, 12'd1, 12'd2, 12'd2047, 12'd2048,
                                 12'd4094, 12'd4095, 12'hAAA, 12'h555};
        // warm-up samples first, including the uptime just under the limit
        send_sample(12'd2000, 32'd0);
        send_sample(12'd1, 32'd2999);
        send_sample(12'd0, 32'd0);
        send_sample(12'd4095, 32'd5);
        foreach (codes[i])
            send_sample(codes[i], 32'd3000);
        send_sample(12'd100, 32'hFFFF_FFFF);
        send_sample(12'd3000, 32'h8000_0000);
        send_sample(12'd2000, 32'd1);
        send_sample(12'd10, 32'd5000);
        send_sample(12'd4000, 32'd5000);
    endtask

    task automatic test_warmup_extremes();
        write_warmup(16'd0);
        send_sample(12'd1500, 32'd0);
        write_warmup(16'hFFFF);
        send_sample(12'd1500, 32'd65534);
        send_sample(12'd1500, 32'd65535);
        send_sample(12'd3000, 32'd0);
    endtask

    task automatic test_random_samples(input int count);
        logic [11:0] code;
        logic [31:0] up;
        for (int i = 0; i < count; i++)
        begin
            if (i % 300 == 0)
                write_warmup(16'($urandom));
            case ($urandom_range(0, 9))
                0: code = 12'($urandom_range(0, 3));
                1: code = 12'($urandom_range(4092, 4095));
                default: code = 12'($urandom);
            endcase
            case ($urandom_range(0, 3))
                0: up = $urandom_range(0, 32'(warmup_limit) + 1);
                1: up = $urandom;
                default: up = 32'(warmup_limit) + $urandom_range(0, 100);
            endcase
            send_sample(code, up);
            if (i == count / 2)
                drain_results();
        end
    endtask

    initial
    begin
        error_count = 0;
        idle_cycles = 0;
        stall_enable = 1'b1;
        rst_n = 1'b0;
        in_valid = 1'b0;
        sample = '0;
        uptime_ms = '0;
        cfg_we = 1'b0;
        cfg_data = '0;
        warmup_limit = gsp_pkg::WARMUP_RESET;
        r0_kohm = 32'd14 << 16;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        test_directed_codes();
        test_warmup_extremes();
        stall_enable = 1'b0;
        test_random_samples(100);
        stall_enable = 1'b1;
        test_random_samples(1030);
        write_warmup(gsp_pkg::WARMUP_RESET);
        drain_results();
        if (error_count == 0)
            $display("tb_gas_sensor_ppm_converter: clean");
        else
            $display("tb_gas_sensor_ppm_converter: errors");
        $finish;
    end

endmodule
